>>> hdl/chmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmr_pkg
// shared types, codes and constants for the cache hit/miss replacement block
// ----------------------------------------------------------------------------
package chmr_pkg;

   // parameter defaults
   localparam int MAX_SLOTS_DEF  = 16;
   localparam int KEY_BITS_DEF   = 16;
   localparam int STAMP_BITS_DEF = 32;

   // fixed field widths
   localparam int REF_KEY_W  = 16;
   localparam int SLOT_OUT_W = 4;
   localparam int COUNT_W    = 32;
   localparam int MODE_W     = 2;
   localparam int SLOTS_W    = 5;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_CACHE_MODE   = 1'b0;
   localparam logic [0:0] REG_SLOTS_IN_USE = 1'b1;
   localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RESET = 5'd4;

   // random victim generator
   localparam int LFSR_W = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

   // remainder unit: dividend width and bits retired per cycle
   localparam int REM_W      = 32;
   localparam int REM_STEP   = 4;
   localparam int REM_DIGITS = REM_W / REM_STEP;

   typedef enum logic [MODE_W-1:0] {
      MODE_DIRECT = 2'd0,
      MODE_RANDOM = 2'd1,
      MODE_LRU    = 2'd2,
      MODE_ROUND  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      DIV_KEY  = 2'd0,
      DIV_LFSR = 2'd1,
      DIV_MISS = 2'd2
   } div_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_LOOK  = 3'd1,
      ST_DIV   = 3'd2,
      ST_SCAN  = 3'd3,
      ST_WRITE = 3'd4
   } state_type;

   typedef struct packed {
      logic        load;
      logic        look;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_take;
      logic        scan_start;
      logic        scan_take;
      logic        commit;
   } ctrl_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     any_match;
      logic     rem_done;
      logic     scan_done;
      logic     out_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> hdl/chmr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module chmr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> hdl/chmr_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmr_rem
// multi-cycle remainder unit, restoring, a few dividend bits per cycle
// ----------------------------------------------------------------------------
module chmr_rem #(
   parameter int DIV_W = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [chmr_pkg::REM_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]           divisor,
   output logic                            done,
   output logic      [DIV_W-1:0]           remainder
);
   import chmr_pkg::*;

   localparam int CNT_W = $clog2(REM_DIGITS + 1);

   logic [REM_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W:0]   trial;

   // retire REM_STEP bits, msb first
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      trial  = '0;
      for (int j = 0; j < REM_STEP; j++) begin
         trial  = {rem_in, dvd_in[REM_W-1]};
         dvd_in = {dvd_in[REM_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(REM_DIGITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   // checked when the result appears; the divisor may be rewritten later
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> rem_ff < divisor)
      else $error("remainder not below divisor");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("remainder done without a run");
   a_not_busy_and_done: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("remainder busy and done together");
endmodule
`default_nettype wire

>>> hdl/chmr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmr_ctrl
// sequencer: accept, lookup, victim selection, commit
// ----------------------------------------------------------------------------
module chmr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire chmr_pkg::dp_status_type status,
   output chmr_pkg::ctrl_cmd_type       cmd
);
   import chmr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (status.mode == MODE_DIRECT) begin
               state_in = ST_DIV;
            end else if (status.any_match) begin
               state_in = ST_WRITE;
            end else if (status.mode == MODE_LRU) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.rem_done) state_in = ST_WRITE;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_LOOK: begin
            if (status.mode == MODE_DIRECT) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_KEY;
            end else begin
               cmd.look = 1'b1;
               if (!status.any_match) begin
                  case (status.mode)
                     MODE_RANDOM: begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_LFSR;
                     end
                     MODE_LRU: begin
                        cmd.scan_start = 1'b1;
                     end
                     default: begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_MISS;
                     end
                  endcase
               end
            end
         end
         ST_DIV: begin
            cmd.div_take = status.rem_done;
         end
         ST_SCAN: begin
            cmd.scan_take = status.scan_done;
         end
         ST_WRITE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while result register is full");
   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_LOOK)
      else $error("accepted beat did not start a lookup");
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_start && cmd.scan_start))
      else $error("remainder and scan started together");
endmodule
`default_nettype wire

>>> hdl/chmr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmr_dp
// datapath: tag lanes, stamp ram, lru scan, remainder unit, counters, result
// ----------------------------------------------------------------------------
module chmr_dp #(
   parameter int MAX_SLOTS  = chmr_pkg::MAX_SLOTS_DEF,
   parameter int KEY_BITS   = chmr_pkg::KEY_BITS_DEF,
   parameter int STAMP_BITS = chmr_pkg::STAMP_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire chmr_pkg::ctrl_cmd_type         cmd,
   output chmr_pkg::dp_status_type             status,
   input  wire chmr_pkg::mode_type             cfg_mode,
   input  wire logic [chmr_pkg::SLOTS_W-1:0]   cfg_slots,
   input  wire logic [chmr_pkg::REF_KEY_W-1:0] req_reference_key,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_was_hit,
   output logic [chmr_pkg::SLOT_OUT_W-1:0]     rsp_slot_used,
   output logic [chmr_pkg::COUNT_W-1:0]        rsp_references_seen,
   output logic [chmr_pkg::COUNT_W-1:0]        rsp_hits_seen
);
   import chmr_pkg::*;

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int NW = $clog2(MAX_SLOTS + 1);

   // active slot count
   logic [NW-1:0] n;
   always_comb begin
      if (cfg_slots == '0) begin
         n = NW'(1);
      end else if (32'(cfg_slots) > 32'(MAX_SLOTS)) begin
         n = NW'(MAX_SLOTS);
      end else begin
         n = NW'(cfg_slots);
      end
   end

   // reference key
   logic [31:0]         key_wide;
   logic [KEY_BITS-1:0] key_ff;
   assign key_wide = 32'(req_reference_key);

   always_ff @(posedge clock) begin
      if (cmd.load) key_ff <= key_wide[KEY_BITS-1:0];
   end

   // tag lanes
   logic [MAX_SLOTS-1:0] valid_ff;
   logic [KEY_BITS-1:0]  tag_ff [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] eq_vec;
   logic [MAX_SLOTS-1:0] match_vec;
   logic [SW-1:0]        first_idx;
   logic                 any_match;

   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_lane
      assign eq_vec[g]    = valid_ff[g] && (tag_ff[g] == key_ff);
      assign match_vec[g] = eq_vec[g] && (32'(g) < 32'(n));
   end

   always_comb begin
      first_idx = '0;
      any_match = 1'b0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            first_idx = SW'(i);
            any_match = 1'b1;
         end
      end
   end

   // counters and random source
   logic [COUNT_W-1:0] ref_cnt_ff;
   logic [COUNT_W-1:0] hit_cnt_ff;
   logic [LFSR_W-1:0]  lfsr_ff;
   logic [LFSR_W-1:0]  lfsr_next;
   logic               lfsr_fb;

   assign lfsr_fb   = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];
   assign lfsr_next = {lfsr_fb, lfsr_ff[LFSR_W-1:1]};

   // remainder unit
   logic [REM_W-1:0] dividend;
   logic             rem_done;
   logic [NW-1:0]    rem_val;

   always_comb begin
      case (cmd.div_sel)
         DIV_KEY:  dividend = REM_W'(key_ff);
         DIV_LFSR: dividend = REM_W'(lfsr_next);
         DIV_MISS: dividend = REM_W'(ref_cnt_ff - hit_cnt_ff);
         default:  dividend = '0;
      endcase
   end

   chmr_rem #(
      .DIV_W (NW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (n),
      .done      (rem_done),
      .remainder (rem_val)
   );

   // lookup result
   logic          hit_ff;
   logic [SW-1:0] slot_ff;
   logic [SW-1:0] rem_slot;
   assign rem_slot = rem_val[SW-1:0];

   // stamp store and lru scan
   logic [NW-1:0]         scan_idx_ff;
   logic                  scan_run_ff;
   logic                  rd_live_ff;
   logic [SW-1:0]         rd_idx_ff;
   logic [STAMP_BITS-1:0] best_stamp_ff;
   logic [SW-1:0]         best_idx_ff;
   logic                  scan_done_ff;
   logic [STAMP_BITS-1:0] ram_rdata;
   logic [STAMP_BITS-1:0] cand;
   logic [COUNT_W-1:0]    stamp_wide;
   logic                  ram_we;

   assign stamp_wide = ref_cnt_ff + COUNT_W'(1);
   assign ram_we     = cmd.commit && (!hit_ff || cfg_mode != MODE_DIRECT);
   // a slot never filled is read as a stamp of zero, since the ram has no reset
   assign cand       = valid_ff[rd_idx_ff] ? ram_rdata : '0;

   chmr_ram #(
      .WIDTH (STAMP_BITS),
      .DEPTH (MAX_SLOTS)
   ) u_stamp_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (stamp_wide[STAMP_BITS-1:0]),
      .raddr (scan_idx_ff[SW-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff  <= 1'b0;
         rd_live_ff   <= 1'b0;
         scan_done_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_run_ff  <= 1'b1;
         rd_live_ff   <= 1'b0;
         scan_done_ff <= 1'b0;
      end else begin
         rd_live_ff <= scan_run_ff;
         if (scan_run_ff && scan_idx_ff == n - NW'(1)) scan_run_ff <= 1'b0;
         if (rd_live_ff && NW'(rd_idx_ff) == n - NW'(1)) scan_done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
      end else if (scan_run_ff && scan_idx_ff != n - NW'(1)) begin
         scan_idx_ff <= scan_idx_ff + NW'(1);
      end
      if (scan_run_ff) rd_idx_ff <= scan_idx_ff[SW-1:0];
      // strict compare keeps the lowest index on ties
      if (rd_live_ff && (rd_idx_ff == '0 || cand < best_stamp_ff)) begin
         best_stamp_ff <= cand;
         best_idx_ff   <= rd_idx_ff;
      end
   end

   // lookup / victim capture
   always_ff @(posedge clock) begin
      if (cmd.look) begin
         hit_ff  <= any_match;
         slot_ff <= first_idx;
      end else if (cmd.div_take) begin
         slot_ff <= rem_slot;
         hit_ff  <= (cfg_mode == MODE_DIRECT) ? eq_vec[rem_slot] : 1'b0;
      end else if (cmd.scan_take) begin
         slot_ff <= best_idx_ff;
         hit_ff  <= 1'b0;
      end
   end

   // state update at commit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         ref_cnt_ff <= '0;
         hit_cnt_ff <= '0;
         lfsr_ff    <= LFSR_SEED;
      end else begin
         if (cmd.div_start && cmd.div_sel == DIV_LFSR) lfsr_ff <= lfsr_next;
         if (cmd.commit) begin
            ref_cnt_ff <= stamp_wide;
            if (hit_ff) begin
               hit_cnt_ff <= hit_cnt_ff + COUNT_W'(1);
            end else begin
               valid_ff[slot_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff) tag_ff[slot_ff] <= key_ff;
   end

   // result register
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [SW-1:0]      rsp_slot_ff;
   logic [COUNT_W-1:0] rsp_refs_ff;
   logic [COUNT_W-1:0] rsp_hits_ff;
   logic [31:0]        rsp_slot_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff  <= hit_ff;
         rsp_slot_ff <= slot_ff;
         rsp_refs_ff <= stamp_wide;
         rsp_hits_ff <= hit_cnt_ff + COUNT_W'(hit_ff);
      end
   end

   assign rsp_slot_wide       = 32'(rsp_slot_ff);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_was_hit         = rsp_hit_ff;
   assign rsp_slot_used       = rsp_slot_wide[SLOT_OUT_W-1:0];
   assign rsp_references_seen = rsp_refs_ff;
   assign rsp_hits_seen       = rsp_hits_ff;

   // status back to the sequencer
   always_comb begin
      status.mode      = cfg_mode;
      status.any_match = any_match;
      status.rem_done  = rem_done;
      status.scan_done = scan_done_ff;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_slot_ff) < 32'(n))
      else $error("reported slot outside the active slots");
   a_ref_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> ref_cnt_ff == $past(ref_cnt_ff) + COUNT_W'(1))
      else $error("reference count did not advance by one");
   a_fill_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !hit_ff |=> valid_ff[$past(slot_ff)])
      else $error("filled slot not marked valid");
   a_hit_is_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && hit_ff |-> valid_ff[slot_ff] && tag_ff[slot_ff] == key_ff)
      else $error("hit reported on a slot that does not hold the key");
endmodule
`default_nettype wire

>>> hdl/cache_hit_miss_replacement.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cache_hit_miss_replacement
// tag-store lookup with direct-mapped or fully associative placement
// ----------------------------------------------------------------------------
// One request beat carries a key; one response beat reports hit or miss, the
// slot that hit or was filled, and the wrapping reference and hit counts. The
// block works on one key at a time. An associative hit goes from accept to
// result through accept, parallel tag compare over active slots, and commit.
// For direct-mapped lookups and random or round robin misses the slot is a
// remainder by the active slot count, computed by a shared restoring remainder
// unit that retires 4 bits of a 32-bit dividend per cycle. On an LRU miss the
// stamps of the n active slots sit in a ram with one registered read port and
// are read one slot per cycle to find the oldest.
// A new key is taken as soon as the previous result has been written to the
// output register, so a stalled response only holds the next key at its
// commit step. No clearing pass is needed after reset. Registers (apb-style,
// pready always high): 0x0 cache_mode (0 direct, 1 random, 2 lru, 3 round
// robin), 0x4 slots_in_use (0 acts as 1, values above MAX_SLOTS act as
// MAX_SLOTS). Write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module cache_hit_miss_replacement #(
   parameter int MAX_SLOTS  = chmr_pkg::MAX_SLOTS_DEF,
   parameter int KEY_BITS   = chmr_pkg::KEY_BITS_DEF,
   parameter int STAMP_BITS = chmr_pkg::STAMP_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [chmr_pkg::REF_KEY_W-1:0]  req_reference_key,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_was_hit,
   output logic [chmr_pkg::SLOT_OUT_W-1:0]      rsp_slot_used,
   output logic [chmr_pkg::COUNT_W-1:0]         rsp_references_seen,
   output logic [chmr_pkg::COUNT_W-1:0]         rsp_hits_seen,
   // register port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [chmr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [chmr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [chmr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import chmr_pkg::*;

   // configuration registers
   mode_type           mode_ff;
   logic [SLOTS_W-1:0] slots_ff;
   logic [0:0]         csr_index;
   logic               csr_write;

   // register index is the word address; the low byte bits are ignored
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_DIRECT;
         slots_ff <= SLOTS_IN_USE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CACHE_MODE:   mode_ff  <= mode_type'(csr_pwdata[MODE_W-1:0]);
            REG_SLOTS_IN_USE: slots_ff <= csr_pwdata[SLOTS_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_index)
         REG_CACHE_MODE:   csr_prdata = CSR_DATA_W'(mode_ff);
         REG_SLOTS_IN_USE: csr_prdata = CSR_DATA_W'(slots_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // sequencer and datapath, joined by command and status only
   ctrl_cmd_type  cmd;
   dp_status_type status;

   chmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   chmr_dp #(
      .MAX_SLOTS  (MAX_SLOTS),
      .KEY_BITS   (KEY_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cfg_mode            (mode_ff),
      .cfg_slots           (slots_ff),
      .req_reference_key   (req_reference_key),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_was_hit         (rsp_was_hit),
      .rsp_slot_used       (rsp_slot_used),
      .rsp_references_seen (rsp_references_seen),
      .rsp_hits_seen       (rsp_hits_seen)
   );

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> cmd.load)
      else $error("accepted request beat not loaded");
   a_hits_not_above_refs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_hit && rsp_references_seen == rsp_hits_seen
      |-> rsp_references_seen != '0)
      else $error("hit reported with no reference counted");
   a_csr_stable_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready && !rsp_valid |=> $stable(mode_ff) || $past(csr_write))
      else $error("mode changed without a register write");
endmodule
`default_nettype wire
